// ----- hdl/wru_pkg.sv -----
`timescale 1ns / 1ps
// wru_pkg: shared types and constants of the water ripple height update unit.
// No dependencies.
package wru_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int HEIGHT_BITS = 16;
	localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
	localparam int POS_BITS    = 10;
	localparam int DIM_BITS    = 11;
	localparam int SKIP_BITS   = 10;
	localparam int SHIFT_BITS  = 4;
	localparam int SUM_BITS    = HEIGHT_BITS + 4;
	localparam int NH_BITS     = HEIGHT_BITS + 2;
	localparam int MIN_DIM     = 3;

	typedef enum logic [1:0] {
		CFG_FIELD_WIDTH   = 2'd0,
		CFG_FIELD_HEIGHT  = 2'd1,
		CFG_TOP_SKIP      = 2'd2,
		CFG_DAMPING_SHIFT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [HEIGHT_BITS-1:0] two_up;
		logic signed [HEIGHT_BITS-1:0] one_up;
		logic signed [HEIGHT_BITS-1:0] older;
	} line_rd_t;

	typedef struct packed {
		logic signed [SUM_BITS-1:0]    sum;
		logic signed [HEIGHT_BITS-1:0] centre;
		logic [POS_BITS-1:0]           row;
		logic [POS_BITS-1:0]           col;
	} calc_in_t;

endpackage

// ----- hdl/water_ripple_height_update_unit.sv -----
`timescale 1ns / 1ps
// water_ripple_height_update_unit: top level of the ripple height update.
// Uses wru_pkg, wru_line_store and wru_calc.
//
// Takes one cell per clock in raster order, sustained unless stalled, and for each
// interior cell returns the damped eight-neighbour update of the cell one row up
// and one column left, with its row and column. Each cell makes a single read-first
// access to three 1024 x 16 row stores, so consecutive cells never contend for an
// entry. A result passes the store read, sum, centre subtract and damping and
// saturation registers. Border cells and skipped top rows give no result. The user
// writes the registers through the cfg port only while the block is idle; the block
// does not enforce it. The stores need no clearing after reset.
module water_ripple_height_update_unit import wru_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [DIM_BITS-1:0]           cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [HEIGHT_BITS-1:0] last_height,
	input  logic signed [HEIGHT_BITS-1:0] older_height,
	input  logic                          frame_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [HEIGHT_BITS-1:0] new_height,
	output logic [POS_BITS-1:0]           cell_row,
	output logic [POS_BITS-1:0]           cell_column
);

	logic [DIM_BITS-1:0]   width_q;
	logic [DIM_BITS-1:0]   height_q;
	logic [SKIP_BITS-1:0]  skip_q;
	logic [SHIFT_BITS-1:0] shift_q;
	logic [POS_BITS-1:0]   row_q;
	logic [POS_BITS-1:0]   col_q;

	logic [DIM_BITS-1:0]   w_eff;
	logic [DIM_BITS-1:0]   h_eff;
	logic [POS_BITS-1:0]   r_pre;
	logic [POS_BITS-1:0]   c_pre;
	logic [POS_BITS-1:0]   r_cur;
	logic [POS_BITS-1:0]   c_cur;
	logic [DIM_BITS-1:0]   r_inc;
	logic [DIM_BITS-1:0]   c_inc;
	logic                  emit;
	logic                  in_fire;

	logic                          v_s1;
	logic                          emit_s1;
	logic signed [HEIGHT_BITS-1:0] cur_s1;
	logic [POS_BITS-1:0]           row_s1;
	logic [POS_BITS-1:0]           col_s1;
	line_rd_t                      rd_s1;

	logic signed [HEIGHT_BITS-1:0] win_q [6];
	logic signed [HEIGHT_BITS-1:0] hold_q;

	logic     calc_ready;
	logic     s1_go;
	calc_in_t calc_in;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(MAX_WIDTH);
			height_q <= DIM_BITS'(MAX_ROWS);
			skip_q   <= '0;
			shift_q  <= SHIFT_BITS'(5);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FIELD_WIDTH:   width_q  <= cfg_data;
				CFG_FIELD_HEIGHT:  height_q <= cfg_data;
				CFG_TOP_SKIP:      skip_q   <= cfg_data[SKIP_BITS-1:0];
				CFG_DAMPING_SHIFT: shift_q  <= cfg_data[SHIFT_BITS-1:0];
				default:           ;
			endcase
		end
	end

	// position of the arriving cell
	assign w_eff = (width_q < DIM_BITS'(MIN_DIM)) ? DIM_BITS'(MIN_DIM) :
		(width_q > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : width_q;
	assign h_eff = (height_q < DIM_BITS'(MIN_DIM)) ? DIM_BITS'(MIN_DIM) :
		(height_q > DIM_BITS'(MAX_ROWS)) ? DIM_BITS'(MAX_ROWS) : height_q;

	assign r_pre = frame_start ? '0 : row_q;
	assign c_pre = frame_start ? '0 : col_q;
	assign c_cur = ({1'b0, c_pre} >= w_eff) ? '0 : c_pre;
	assign r_cur = ({1'b0, r_pre} >= h_eff) ? '0 : r_pre;
	assign c_inc = {1'b0, c_cur} + DIM_BITS'(1);
	assign r_inc = {1'b0, r_cur} + DIM_BITS'(1);
	assign emit  = (c_cur >= POS_BITS'(2)) &&
		({1'b0, r_cur} >= (DIM_BITS'(skip_q) + DIM_BITS'(2)));

	assign in_ready = !v_s1 || s1_go;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_fire) begin
			if (c_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (r_inc >= h_eff) ? '0 : r_inc[POS_BITS-1:0];
			end else begin
				col_q <= c_inc[POS_BITS-1:0];
				row_q <= r_cur;
			end
		end
	end

	wru_line_store u_store (
		.clk      (clk),
		.we       (in_fire),
		.addr     (c_cur[ADDR_BITS-1:0]),
		.row_odd  (r_cur[0]),
		.last_in  (last_height),
		.older_in (older_height),
		.rd       (rd_s1)
	);

	// stage 1: store data back, window slide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			emit_s1 <= emit;
			cur_s1  <= last_height;
			row_s1  <= r_cur;
			col_s1  <= c_cur;
		end
		if (s1_go) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= rd_s1.two_up;
			win_q[1] <= rd_s1.one_up;
			win_q[2] <= cur_s1;
			hold_q   <= rd_s1.older;
		end
	end

	assign s1_go = v_s1 && (!emit_s1 || calc_ready);

	assign calc_in.sum = SUM_BITS'(win_q[3]) + SUM_BITS'(win_q[4]) + SUM_BITS'(win_q[5])
		+ SUM_BITS'(win_q[0]) + SUM_BITS'(win_q[2]) + SUM_BITS'(rd_s1.two_up)
		+ SUM_BITS'(rd_s1.one_up) + SUM_BITS'(cur_s1);
	assign calc_in.centre = hold_q;
	assign calc_in.row    = row_s1 - POS_BITS'(1);
	assign calc_in.col    = col_s1 - POS_BITS'(1);

	wru_calc u_calc (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v_s1 && emit_s1),
		.in_ready      (calc_ready),
		.in_data       (calc_in),
		.damping_shift (shift_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.new_height    (new_height),
		.cell_row      (cell_row),
		.cell_column   (cell_column)
	);

	a_fire_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> v_s1)
		else $error("accepted beat did not reach stage 1");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_go |=> v_s1 && $stable(col_s1) && $stable(row_s1))
		else $error("stage 1 lost or changed while stalled");

	a_frame_col: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && frame_start |=> col_q == POS_BITS'(1) && row_q == '0)
		else $error("frame start did not restart position");

	a_emit_interior: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && emit_s1 |-> col_s1 >= POS_BITS'(2) && row_s1 >= POS_BITS'(2))
		else $error("border cell flagged for update");

endmodule

// ----- hdl/wru_line_store.sv -----
`timescale 1ns / 1ps
// wru_line_store: even/odd row stores of last heights and the row store of older heights.
// Read-first synchronous arrays, one access per accepted beat. Uses wru_pkg.
module wru_line_store import wru_pkg::*; (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ADDR_BITS-1:0]          addr,
	input  logic                          row_odd,
	input  logic signed [HEIGHT_BITS-1:0] last_in,
	input  logic signed [HEIGHT_BITS-1:0] older_in,
	output line_rd_t                      rd
);

	logic signed [HEIGHT_BITS-1:0] even_mem [MAX_WIDTH];
	logic signed [HEIGHT_BITS-1:0] odd_mem [MAX_WIDTH];
	logic signed [HEIGHT_BITS-1:0] older_mem [MAX_WIDTH];

	logic signed [HEIGHT_BITS-1:0] even_rd_q;
	logic signed [HEIGHT_BITS-1:0] odd_rd_q;
	logic signed [HEIGHT_BITS-1:0] older_rd_q;
	logic                          odd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			even_rd_q  <= even_mem[addr];
			odd_rd_q   <= odd_mem[addr];
			older_rd_q <= older_mem[addr];
			odd_q      <= row_odd;
			if (row_odd) begin
				odd_mem[addr] <= last_in;
			end else begin
				even_mem[addr] <= last_in;
			end
			older_mem[addr] <= older_in;
		end
	end

	// same parity bank holds row r-2, the other row r-1
	assign rd.two_up = odd_q ? odd_rd_q : even_rd_q;
	assign rd.one_up = odd_q ? even_rd_q : odd_rd_q;
	assign rd.older  = older_rd_q;

endmodule

// ----- hdl/wru_calc.sv -----
`timescale 1ns / 1ps
// wru_calc: arithmetic pipeline from window sum to damped, saturated height.
// Three registered stages with valid/ready chaining. Uses wru_pkg.
module wru_calc import wru_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  calc_in_t                      in_data,
	input  logic [SHIFT_BITS-1:0]         damping_shift,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [HEIGHT_BITS-1:0] new_height,
	output logic [POS_BITS-1:0]           cell_row,
	output logic [POS_BITS-1:0]           cell_column
);

	localparam logic signed [NH_BITS-1:0] SAT_HI = NH_BITS'((1 << (HEIGHT_BITS - 1)) - 1);
	localparam logic signed [NH_BITS-1:0] SAT_LO = -SAT_HI - NH_BITS'(1);

	logic                          v_s2;
	calc_in_t                      d_s2;
	logic                          v_s3;
	logic signed [NH_BITS-1:0]     nh_s3;
	logic [POS_BITS-1:0]           row_s3;
	logic [POS_BITS-1:0]           col_s3;
	logic                          out_valid_q;
	logic signed [HEIGHT_BITS-1:0] height_q;
	logic [POS_BITS-1:0]           row_q;
	logic [POS_BITS-1:0]           col_q;

	logic                          out_free;
	logic                          go3;
	logic                          free3;
	logic                          go2;
	logic signed [NH_BITS-1:0]     nh_c;
	logic signed [NH_BITS-1:0]     damp_c;
	logic signed [HEIGHT_BITS-1:0] sat_c;

	assign out_free = !out_valid_q || out_ready;
	assign go3      = v_s3 && out_free;
	assign free3    = !v_s3 || out_free;
	assign go2      = v_s2 && free3;
	assign in_ready = !v_s2 || go2;

	assign nh_c   = NH_BITS'(d_s2.sum >>> 2) - NH_BITS'(d_s2.centre);
	assign damp_c = nh_s3 - (nh_s3 >>> damping_shift);

	always_comb begin
		if (damp_c > SAT_HI) begin
			sat_c = HEIGHT_BITS'(SAT_HI);
		end else if (damp_c < SAT_LO) begin
			sat_c = HEIGHT_BITS'(SAT_LO);
		end else begin
			sat_c = HEIGHT_BITS'(damp_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				v_s2 <= 1'b1;
			end else if (go2) begin
				v_s2 <= 1'b0;
			end
			if (go2) begin
				v_s3 <= 1'b1;
			end else if (go3) begin
				v_s3 <= 1'b0;
			end
			if (go3) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			d_s2 <= in_data;
		end
		if (go2) begin
			nh_s3  <= nh_c;
			row_s3 <= d_s2.row;
			col_s3 <= d_s2.col;
		end
		if (go3) begin
			height_q <= sat_c;
			row_q    <= row_s3;
			col_q    <= col_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign new_height  = height_q;
	assign cell_row    = row_q;
	assign cell_column = col_q;

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !free3 |=> v_s2 && $stable(d_s2))
		else $error("stage 2 lost or changed while stalled");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !out_free |=> v_s3 && $stable(nh_s3))
		else $error("stage 3 lost or changed while stalled");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s3))
		else $error("result raised without stage 3 item");

endmodule

// ----- dv/water_ripple_height_update_unit_tb.sv -----
`timescale 1ns / 1ps
// water_ripple_height_update_unit_tb: self-checking bench for the ripple height update unit.
// Depends on wru_pkg and water_ripple_height_update_unit; a scoreboard class predicts each
// damped cell update from the streamed field and checks the result beats in order.

import wru_pkg::*;

typedef struct {
	logic signed [HEIGHT_BITS-1:0] height;
	logic [POS_BITS-1:0]           row;
	logic [POS_BITS-1:0]           col;
} ripple_cell_t;

class ripple_scoreboard;
	int field_width;
	int field_height;
	int top_skip;
	int damp_shift;
	int last_rows[2][MAX_WIDTH];
	int older_row[MAX_WIDTH+1];
	int win[6];
	int row_ctr;
	int col_ctr;
	int errors;
	ripple_cell_t awaited_cells[$];

	function new();
		field_width  = MAX_WIDTH;
		field_height = MAX_ROWS;
		top_skip     = 0;
		damp_shift   = 5;
		row_ctr      = 0;
		col_ctr      = 0;
		errors       = 0;
	endfunction

	function void set_reg(cfg_idx_t idx, logic [DIM_BITS-1:0] data);
		case (idx)
			CFG_FIELD_WIDTH:   field_width  = data;
			CFG_FIELD_HEIGHT:  field_height = data;
			CFG_TOP_SKIP:      top_skip     = data[SKIP_BITS-1:0];
			CFG_DAMPING_SHIFT: damp_shift   = data[SHIFT_BITS-1:0];
			default:           ;
		endcase
	endfunction

	function int pending();
		return awaited_cells.size();
	endfunction

	// one accepted cell: updates the windows and, for an interior cell, queues the
	// damped height of the cell one row up and one column left
	function void take_cell(logic signed [HEIGHT_BITS-1:0] lh, logic signed [HEIGHT_BITS-1:0] oh,
			logic fs);
		int w, h, r, c, up2, up1, centre, sum, nh, hi, lo;
		ripple_cell_t upd;
		w = (field_width < MIN_DIM) ? MIN_DIM : (field_width > MAX_WIDTH) ? MAX_WIDTH : field_width;
		h = (field_height < MIN_DIM) ? MIN_DIM : (field_height > MAX_ROWS) ? MAX_ROWS : field_height;
		if (fs) begin
			row_ctr = 0;
			col_ctr = 0;
		end
		if (col_ctr >= w)
			col_ctr = 0;
		if (row_ctr >= h)
			row_ctr = 0;
		r = row_ctr;
		c = col_ctr;
		up2 = last_rows[r % 2][c];
		up1 = last_rows[(r + 1) % 2][c];
		last_rows[r % 2][c] = lh;
		centre = older_row[MAX_WIDTH];
		older_row[MAX_WIDTH] = older_row[c];
		older_row[c] = oh;
		if (c >= 2 && r >= 2 + top_skip) begin
			hi = (1 << (HEIGHT_BITS - 1)) - 1;
			lo = -hi - 1;
			sum = win[3] + win[4] + win[5] + win[0] + win[2] + up2 + up1 + lh;
			nh = (sum >>> 2) - centre;
			nh = nh - (nh >>> damp_shift);
			if (nh > hi)
				nh = hi;
			if (nh < lo)
				nh = lo;
			upd.height = nh[HEIGHT_BITS-1:0];
			upd.row    = POS_BITS'(r - 1);
			upd.col    = POS_BITS'(c - 1);
			awaited_cells.push_back(upd);
		end
		win[3] = win[0];
		win[4] = win[1];
		win[5] = win[2];
		win[0] = up2;
		win[1] = up1;
		win[2] = lh;
		col_ctr = c + 1;
		if (col_ctr >= w) begin
			col_ctr = 0;
			row_ctr = r + 1;
			if (row_ctr >= h)
				row_ctr = 0;
		end
	endfunction

	function void check_height(logic signed [HEIGHT_BITS-1:0] height, logic [POS_BITS-1:0] row,
			logic [POS_BITS-1:0] col);
		ripple_cell_t want;
		if (awaited_cells.size() == 0) begin
			errors++;
			if (errors <= 50)
				$display("%0t ns: unexpected beat, height %0d at row %0d column %0d",
					$time, height, row, col);
			return;
		end
		want = awaited_cells.pop_front();
		if (height !== want.height || row !== want.row || col !== want.col) begin
			errors++;
			if (errors <= 50)
				$display("%0t ns: expected height %0d row %0d column %0d, got %0d row %0d column %0d",
					$time, want.height, want.row, want.col, height, row, col);
		end
	endfunction
endclass

module water_ripple_height_update_unit_tb;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 16;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          cfg_valid    = 1'b0;
	logic                          cfg_ready;
	logic [1:0]                    cfg_index    = '0;
	logic [DIM_BITS-1:0]           cfg_data     = '0;
	logic                          in_valid     = 1'b0;
	logic                          in_ready;
	logic signed [HEIGHT_BITS-1:0] last_height  = '0;
	logic signed [HEIGHT_BITS-1:0] older_height = '0;
	logic                          frame_start  = 1'b0;
	logic                          out_valid;
	logic                          out_ready    = 1'b0;
	logic signed [HEIGHT_BITS-1:0] new_height;
	logic [POS_BITS-1:0]           cell_row;
	logic [POS_BITS-1:0]           cell_column;

	int src_idle_pct = 7;
	int snk_idle_pct = 72;
	int cycle_count  = 0;

	logic                          result_beat = 1'b0;
	logic signed [HEIGHT_BITS-1:0] beat_height;
	logic [POS_BITS-1:0]           beat_row;
	logic [POS_BITS-1:0]           beat_col;

	ripple_scoreboard sb = new();

	water_ripple_height_update_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.last_height  (last_height),
		.older_height (older_height),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.new_height   (new_height),
		.cell_row     (cell_row),
		.cell_column  (cell_column)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= snk_idle_pct);
	end

	// capture the result beat at the rising edge; the negedge block below checks it
	always @(posedge clk) begin
		result_beat = arst_n && out_valid && out_ready;
		beat_height = new_height;
		beat_row    = cell_row;
		beat_col    = cell_column;
	end

	always @(negedge clk) begin
		if (result_beat)
			sb.check_height(beat_height, beat_row, beat_col);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic signed [HEIGHT_BITS-1:0] rand_height();
		case ($urandom_range(9))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return 16'sh0000;
			3:       return 16'shFFFF;
			4:       return HEIGHT_BITS'(int'($urandom_range(0, 64)) - 32);
			default: return HEIGHT_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [DIM_BITS-1:0] pick_dim();
		case ($urandom_range(7))
			0:       return DIM_BITS'($urandom_range(0, 3));
			1:       return DIM_BITS'($urandom_range(17, 40));
			default: return DIM_BITS'($urandom_range(4, 12));
		endcase
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [DIM_BITS-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h,
			input logic [DIM_BITS-1:0] skip, input logic [DIM_BITS-1:0] shift);
		write_reg(CFG_FIELD_WIDTH, w);
		write_reg(CFG_FIELD_HEIGHT, h);
		write_reg(CFG_TOP_SKIP, skip);
		write_reg(CFG_DAMPING_SHIFT, shift);
	endtask

	task automatic send_cell(input logic signed [HEIGHT_BITS-1:0] lh,
			input logic signed [HEIGHT_BITS-1:0] oh, input logic fs);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		last_height  = lh;
		older_height = oh;
		frame_start  = fs;
		do @(posedge clk); while (!in_ready);
		sb.take_cell(lh, oh, fs);
	endtask

	// stop sending, wait for every awaited beat, then let cells without a result retire
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_frame(input int n_cells, input int pause_at, input int noise_pct);
		for (int i = 0; i < n_cells; i++) begin
			if (i == pause_at)
				drain_results();
			send_cell(rand_height(), rand_height(), i == 0 || $urandom_range(99) < noise_pct);
		end
	endtask

	initial begin
		int random_cells;
		int phase_no;
		int n;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// degenerate sizes act as 3x3: saturation both ways, wrap, restart mid-row
		configure(0, 1, 0, 15);
		for (int i = 0; i < 9; i++)
			send_cell(16'sh7FFF, 16'sh8000, i == 0);
		for (int i = 0; i < 9; i++)
			send_cell(16'sh8000, 16'sh7FFF, 1'b0);
		send_cell(16'sh0001, 16'sh0000, 1'b0);
		send_cell(16'shFFFF, 16'sh5555, 1'b0);
		for (int i = 0; i < 5; i++)
			send_cell(16'shAAAA, 16'shFFFF, i == 0);

		// oversized width and height clamp to the maximum
		drain_results();
		configure(2047, 2047, 0, 4);
		run_frame(2 * MAX_WIDTH + 8, -1, 0);

		// skip beyond the field: no row qualifies
		drain_results();
		configure(4, 5, 1023, 7);
		run_frame(60, -1, 2);

		random_cells = 0;
		phase_no = 0;
		while (random_cells < 600) begin
			if (random_cells >= 400) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else if (random_cells >= 200) begin
				src_idle_pct = 72;
				snk_idle_pct = 7;
			end
			drain_results();
			if (phase_no == 0 || $urandom_range(3) != 0)
				write_reg(CFG_FIELD_WIDTH, pick_dim());
			if (phase_no == 0 || $urandom_range(3) != 0)
				write_reg(CFG_FIELD_HEIGHT, pick_dim());
			if (phase_no == 0 || $urandom_range(3) != 0)
				write_reg(CFG_TOP_SKIP, ($urandom_range(7) == 0) ?
					DIM_BITS'($urandom_range(0, 2047)) :
					DIM_BITS'($urandom_range(0, 3) | ($urandom_range(1) << SKIP_BITS)));
			if (phase_no == 0 || $urandom_range(3) != 0)
				write_reg(CFG_DAMPING_SHIFT, DIM_BITS'($urandom_range(0, 2047)));
			n = $urandom_range(40, 200);
			run_frame(n, (phase_no % 3 == 0) ? int'($urandom_range(1, n - 1)) : -1, 2);
			random_cells += n;
			phase_no++;
		end

		drain_results();
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
